### rtl/hbdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbdr_pkg;

  localparam int unsigned DutyBits  = 8;
  localparam int unsigned PauseBits = 16;

  localparam logic [PauseBits-1:0] PauseReset = PauseBits'(50);

  typedef enum logic [3:0] {
    PhIdle  = 4'b0001,
    PhRamp  = 4'b0010,
    PhDown  = 4'b0100,
    PhPause = 4'b1000
  } ramp_phase_e;

  typedef enum logic {
    ActTick = 1'b0,
    ActCmd  = 1'b1
  } action_e;

  typedef struct packed {
    logic                action;
    logic [DutyBits-1:0] target_duty;
    logic                target_direction;
  } in_item_t;

  typedef struct packed {
    logic [DutyBits-1:0] right_high_duty;
    logic [DutyBits-1:0] left_high_duty;
    logic                left_low_on;
    logic                right_low_on;
    logic [DutyBits-1:0] present_duty;
    logic                present_direction;
    logic                busy_res;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/hbdr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module hbdr_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              step_i,
  input  wire hbdr_pkg::in_item_t          item_i,
  input  wire [hbdr_pkg::PauseBits-1:0]    pause_ticks_i,
  output hbdr_pkg::out_item_t              result_o
);
  import hbdr_pkg::*;

  logic [DutyBits-1:0]  duty_q, duty_d;
  logic                 dir_q, dir_d;
  logic [DutyBits-1:0]  active_q, active_d;
  logic [DutyBits-1:0]  saved_q, saved_d;
  logic                 pend_q, pend_d;
  ramp_phase_e          phase_q, phase_d;
  logic [PauseBits-1:0] pause_q, pause_d;
  logic                 low_q, low_d;

  always_comb begin
    duty_d   = duty_q;
    dir_d    = dir_q;
    active_d = active_q;
    saved_d  = saved_q;
    pend_d   = pend_q;
    phase_d  = phase_q;
    pause_d  = pause_q;
    low_d    = low_q;
    if (item_i.action == ActCmd) begin
      if (phase_q == PhDown || phase_q == PhPause) begin
        saved_d = item_i.target_duty;
        pend_d  = item_i.target_direction;
      end else if (item_i.target_direction != dir_q) begin
        saved_d  = item_i.target_duty;
        pend_d   = item_i.target_direction;
        active_d = '0;
        phase_d  = PhDown;
      end else begin
        active_d = item_i.target_duty;
        phase_d  = PhRamp;
      end
    end else begin
      unique case (phase_q)
        PhRamp: begin
          if (active_q > duty_q) begin
            low_d  = 1'b1;
            duty_d = duty_q + DutyBits'(1);
          end else if (active_q < duty_q) begin
            duty_d = duty_q - DutyBits'(1);
          end
          if (duty_d == active_q) phase_d = PhIdle;
          if (duty_d == '0) low_d = 1'b0;
        end
        PhDown: begin
          if (duty_q != '0) duty_d = duty_q - DutyBits'(1);
          if (duty_d == '0) begin
            low_d   = 1'b0;
            pause_d = '0;
            phase_d = PhPause;
          end
        end
        PhPause: begin
          if (pause_q < pause_ticks_i) begin
            pause_d = pause_q + PauseBits'(1);
          end else begin
            dir_d    = pend_q;
            active_d = saved_q;
            phase_d  = PhRamp;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q   <= '0;
      dir_q    <= 1'b0;
      active_q <= '0;
      saved_q  <= '0;
      pend_q   <= 1'b0;
      phase_q  <= PhIdle;
      pause_q  <= '0;
      low_q    <= 1'b0;
    end else if (step_i) begin
      duty_q   <= duty_d;
      dir_q    <= dir_d;
      active_q <= active_d;
      saved_q  <= saved_d;
      pend_q   <= pend_d;
      phase_q  <= phase_d;
      pause_q  <= pause_d;
      low_q    <= low_d;
    end
  end

  always_comb begin
    result_o.right_high_duty   = dir_d ? duty_d : '0;
    result_o.left_high_duty    = dir_d ? '0 : duty_d;
    result_o.left_low_on       = low_d & dir_d;
    result_o.right_low_on      = low_d & ~dir_d;
    result_o.present_duty      = duty_d;
    result_o.present_direction = dir_d;
    result_o.busy_res          = (phase_d != PhIdle);
  end

  // low side never on at zero duty
  a_low_off_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_q == '0) |-> !low_q)
    else $error("low side on at zero duty");

  a_pause_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPause) |-> (duty_q == '0))
    else $error("pause with nonzero duty");

  a_down_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDown) |-> (active_q == '0))
    else $error("ramp-down with nonzero target");

  a_idle_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (duty_q == active_q))
    else $error("idle but duty not at target");

endmodule

`default_nettype wire

### rtl/h_bridge_duty_ramp_with_reversal_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                           Beat
// in        in_valid_i/in_ready_o/in_data_i   one tick or command
// out       out_valid_o/out_ready_i/out_data_o one bridge drive result per item
// cfg       cfg_we_i/cfg_wdata_i              reverse pause tick count
//
// One item per clock unless in_ready_o is low; result appears the cycle after
// acceptance, from the core's next state captured in the output register.
// in_ready_o stays high while the output register is empty or being drained.
// Async active-low reset: duty 0, direction 0, idle, pause count register 50.

module h_bridge_duty_ramp_with_reversal_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire hbdr_pkg::in_item_t       in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output hbdr_pkg::out_item_t           out_data_o,
  input  wire                           cfg_we_i,
  input  wire [hbdr_pkg::PauseBits-1:0] cfg_wdata_i
);
  import hbdr_pkg::*;

  logic [PauseBits-1:0] pause_ticks_q;
  logic                 out_valid_q;
  out_item_t            out_data_q;
  out_item_t            result;
  logic                 accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  hbdr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .item_i        (in_data_i),
    .pause_ticks_i (pause_ticks_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_ticks_q <= PauseReset;
    end else if (cfg_we_i) begin
      pause_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import hbdr_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [PauseBits-1:0] cfg_wdata = '0;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned errors    = 0;

  // predicted bridge state
  logic [DutyBits-1:0]  m_duty   = '0;
  logic                 m_dir    = 1'b0;
  logic [DutyBits-1:0]  m_active = '0;
  logic [DutyBits-1:0]  m_saved  = '0;
  logic                 m_pend   = 1'b0;
  ramp_phase_e          m_phase  = PhIdle;
  logic [PauseBits-1:0] m_pcount = '0;
  logic                 m_low    = 1'b0;
  logic [PauseBits-1:0] m_pause  = PauseReset;

  out_item_t drive_q[$];

  h_bridge_duty_ramp_with_reversal_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  task automatic advance_bridge(input in_item_t it);
    out_item_t r;
    if (it.action == ActCmd) begin
      if (m_phase == PhDown || m_phase == PhPause) begin
        m_saved = it.target_duty;
        m_pend  = it.target_direction;
      end else if (it.target_direction != m_dir) begin
        m_saved  = it.target_duty;
        m_pend   = it.target_direction;
        m_active = '0;
        m_phase  = PhDown;
      end else begin
        m_active = it.target_duty;
        m_phase  = PhRamp;
      end
    end else begin
      case (m_phase)
        PhRamp: begin
          if (m_active > m_duty) begin
            m_low  = 1'b1;
            m_duty = m_duty + DutyBits'(1);
          end else if (m_active < m_duty) begin
            m_duty = m_duty - DutyBits'(1);
          end
          if (m_duty == m_active) m_phase = PhIdle;
          if (m_duty == '0) m_low = 1'b0;
        end
        PhDown: begin
          if (m_duty != '0) m_duty = m_duty - DutyBits'(1);
          if (m_duty == '0) begin
            m_low    = 1'b0;
            m_pcount = '0;
            m_phase  = PhPause;
          end
        end
        PhPause: begin
          if (m_pcount < m_pause) begin
            m_pcount = m_pcount + PauseBits'(1);
          end else begin
            m_dir    = m_pend;
            m_active = m_saved;
            m_phase  = PhRamp;
          end
        end
        default: ;
      endcase
    end
    r.right_high_duty   = m_dir ? m_duty : '0;
    r.left_high_duty    = m_dir ? '0 : m_duty;
    r.left_low_on       = m_low & m_dir;
    r.right_low_on      = m_low & ~m_dir;
    r.present_duty      = m_duty;
    r.present_direction = m_dir;
    r.busy_res          = (m_phase != PhIdle);
    drive_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
      end else begin
        e = drive_q.pop_front();
        check_field("right_high_duty", e.right_high_duty, out_data.right_high_duty);
        check_field("left_high_duty", e.left_high_duty, out_data.left_high_duty);
        check_field("left_low_on", e.left_low_on, out_data.left_low_on);
        check_field("right_low_on", e.right_low_on, out_data.right_low_on);
        check_field("present_duty", e.present_duty, out_data.present_duty);
        check_field("present_direction", e.present_direction,
                    out_data.present_direction);
        check_field("busy_res", e.busy_res, out_data.busy_res);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input action_e act, input logic [DutyBits-1:0] tgt,
                           input logic dir);
    in_item_t it;
    it.action           = act;
    it.target_duty      = tgt;
    it.target_direction = dir;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    advance_bridge(it);
    @(negedge clk);
  endtask

  task automatic tick();
    send_item(ActTick, DutyBits'($urandom), 1'($urandom));
  endtask

  task automatic command(input logic [DutyBits-1:0] tgt, input logic dir);
    send_item(ActCmd, tgt, dir);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_pause(input logic [PauseBits-1:0] v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    m_pause   = v;
  endtask

  task automatic test_ramp();
    tick();
    command(8'd255, 1'b0);
    tick();
    tick();
    command(8'd0, 1'b0);
    repeat (3) tick();
  endtask

  task automatic test_reversal();
    set_pause(16'd2);
    command(8'd3, 1'b0);
    repeat (2) tick();
    command(8'd170, 1'b1);
    tick();
    command(8'd85, 1'b0);
    tick();
    command(8'd4, 1'b1);
    repeat (4) tick();
  endtask

  task automatic test_zero_pause();
    set_pause(16'd0);
    command(8'd1, 1'b0);
    repeat (3) tick();
  endtask

  task automatic test_pause_lowered();
    set_pause(16'hFFFF);
    command(8'd2, 1'b1);
    while (m_phase != PhPause) tick();
    repeat (2) tick();
    set_pause(16'd1);
    repeat (3) tick();
  endtask

  task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                             input logic [PauseBits-1:0] pause, input int n);
    int sent;
    int run;
    set_pause(pause);
    idle_pct  = s_pct;
    stall_pct = r_pct;
    sent      = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 70) command(DutyBits'($urandom_range(0, 20)), 1'($urandom));
      else command(DutyBits'($urandom), 1'($urandom));
      sent++;
      run = $urandom_range(1, 40);
      repeat (run) begin
        if ($urandom_range(99) < 8) command(DutyBits'($urandom), 1'($urandom));
        else tick();
        sent++;
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_ramp();
    test_reversal();
    test_zero_pause();
    test_pause_lowered();
    test_random(0, 0, 16'd3, 170);
    test_random(81, 0, 16'd0, 170);
    test_random(0, 81, 16'd1, 170);
    test_random(30, 30, PauseBits'($urandom_range(0, 6)), 170);
    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
